[design/pse_pkg.sv]
package pse_pkg;

  localparam int StackDepth  = 1024;
  localparam int MaxExponent = 31;
  localparam int PtrW        = $clog2(StackDepth) + 1;
  localparam int AddrW       = $clog2(StackDepth);
  localparam int DataW       = 32;
  localparam int DepthW      = 10;

  localparam logic [2:0] FUNC_PUSH  = 3'd0;
  localparam logic [2:0] FUNC_ADD   = 3'd1;
  localparam logic [2:0] FUNC_SUB   = 3'd2;
  localparam logic [2:0] FUNC_MUL   = 3'd3;
  localparam logic [2:0] FUNC_DIV   = 3'd4;
  localparam logic [2:0] FUNC_POW   = 3'd5;
  localparam logic [2:0] FUNC_CLEAR = 3'd6;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_UNDER    = 3'd1;
  localparam logic [2:0] ST_OVER     = 3'd2;
  localparam logic [2:0] ST_DIV_ZERO = 3'd3;
  localparam logic [2:0] ST_BAD_EXP  = 3'd4;
  localparam logic [2:0] ST_SAT      = 3'd5;

  // stack read address select
  localparam logic [1:0] RD_SEL_TOP  = 2'd0;
  localparam logic [1:0] RD_SEL_NEXT = 2'd1;
  localparam logic [1:0] RD_SEL_NEW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_TOP, S_RD_NEXT, S_LATCH, S_EXEC, S_ITER,
    S_WRITE, S_RD_RES, S_RES_WAIT, S_OUT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       take_in;    // latch input word
    logic [1:0] rd_sel;     // top, next or new top
    logic       rd_en;
    logic       latch_b;    // capture TOP from RAM
    logic       latch_a;    // capture NEXT from RAM
    logic       exec;       // start/one-shot op
    logic       iter;       // one iteration step
    logic       commit;     // write result and update pointer
    logic       grab_top;   // capture top read data for output
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_op;
    logic is_push;
    logic is_clear;
    logic underflow;
    logic full;
    logic fault;
    logic iter_done;
    logic nonempty;
  } dp_stat_t;

  function automatic logic [DataW-1:0] sat32(input logic signed [65:0] v, output logic s);
    if (v > 66'sh7FFFFFFF) begin
      s = 1'b1; return 32'h7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      s = 1'b1; return 32'h80000000;
    end else begin
      s = 1'b0; return v[31:0];
    end
  endfunction

endpackage

[design/postfix_stack_evaluator.sv]
// Push, clear, unused codes and underflow read the top, write, reread and present the
// new top; add/subtract and the two faults also read NEXT, latch and execute. Multiply
// adds a multiplier pass, divide 64 restoring-divider steps, power a multiply step for
// each exponent unit. One word at a time; next word accepted in the cycle after the result
// is taken. The stack lives in a registered-read RAM; multiplier and divider set operator
// latency. Reset (rst_ni low, async): controller idle, stack empty; RAM is not cleared.
module postfix_stack_evaluator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      func_i,
  input  logic signed [pse_pkg::DataW-1:0] operand_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [pse_pkg::DataW-1:0] top_value_o,
  output logic [pse_pkg::DepthW-1:0]      stack_depth_o,
  output logic [2:0]                      status_o
);
  pse_pkg::dp_cmd_t  cmd;
  pse_pkg::dp_stat_t stat;

  // sequence each word: read operands, run the unit, write back, reread top
  pse_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  // stack RAM, pointer, adder, multiplier and divider
  pse_datapath u_dp (
    .clk_i, .rst_ni, .func_i, .operand_value_i, .cmd_i(cmd), .stat_o(stat),
    .top_value_o, .stack_depth_o, .status_o
  );
endmodule

[design/pse_ram.sv]
module pse_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/pse_ctrl.sv]
module pse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pse_pkg::dp_stat_t stat_i,
  output pse_pkg::dp_cmd_t  cmd_o
);
  pse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pse_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pse_pkg::S_IDLE: if (in_valid_i) state_d = pse_pkg::S_RD_TOP;
      pse_pkg::S_RD_TOP: begin
        if (stat_i.is_op && !stat_i.underflow) state_d = pse_pkg::S_RD_NEXT;
        else                                   state_d = pse_pkg::S_WRITE;
      end
      pse_pkg::S_RD_NEXT:  state_d = pse_pkg::S_LATCH;
      pse_pkg::S_LATCH:    state_d = pse_pkg::S_EXEC;
      pse_pkg::S_EXEC:     state_d = pse_pkg::S_ITER;
      pse_pkg::S_ITER:     if (stat_i.iter_done) state_d = pse_pkg::S_WRITE;
      pse_pkg::S_WRITE:    state_d = pse_pkg::S_RD_RES;
      pse_pkg::S_RD_RES:   state_d = pse_pkg::S_RES_WAIT;
      pse_pkg::S_RES_WAIT: state_d = pse_pkg::S_OUT;
      pse_pkg::S_OUT:      if (!out_stall_i) state_d = pse_pkg::S_IDLE;
      default:             state_d = pse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != pse_pkg::S_IDLE);
    out_valid_o = (state_q == pse_pkg::S_OUT);
    unique case (state_q)
      pse_pkg::S_IDLE:     cmd_o.take_in = in_valid_i;
      pse_pkg::S_RD_TOP:   begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = pse_pkg::RD_SEL_TOP; end
      pse_pkg::S_RD_NEXT:  begin
        cmd_o.rd_en = 1'b1; cmd_o.rd_sel = pse_pkg::RD_SEL_NEXT; cmd_o.latch_b = 1'b1;
      end
      pse_pkg::S_LATCH:    cmd_o.latch_a = 1'b1;
      pse_pkg::S_EXEC:     cmd_o.exec = 1'b1;
      pse_pkg::S_ITER:     cmd_o.iter = 1'b1;
      pse_pkg::S_WRITE:    cmd_o.commit = 1'b1;
      pse_pkg::S_RD_RES:   begin cmd_o.rd_en = 1'b1; cmd_o.rd_sel = pse_pkg::RD_SEL_NEW; end
      pse_pkg::S_RES_WAIT: cmd_o.grab_top = 1'b1;
      pse_pkg::S_OUT:      ;
      default:             ;
    endcase
  end
endmodule

[design/pse_datapath.sv]
module pse_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [2:0]                     func_i,
  input  logic signed [pse_pkg::DataW-1:0] operand_value_i,
  input  pse_pkg::dp_cmd_t               cmd_i,
  output pse_pkg::dp_stat_t              stat_o,
  output logic signed [pse_pkg::DataW-1:0] top_value_o,
  output logic [pse_pkg::DepthW-1:0]     stack_depth_o,
  output logic [2:0]                     status_o
);
  localparam int W = pse_pkg::DataW;
  localparam int AW = pse_pkg::AddrW;
  localparam int PW = pse_pkg::PtrW;

  logic [2:0]          func_q;
  logic [W-1:0]        push_q;
  logic [PW-1:0]       ptr_q;
  logic signed [W-1:0] a_q, b_q, r_q;
  logic [2:0]          st_q;
  logic                sat_q, fault_q;
  logic [7:0]          cnt_q;         // power iterations or divider bits
  logic [63:0]         rem_q;         // divider remainder (magnitude)
  logic [63:0]         quo_q;
  logic [63:0]         dvd_q;
  logic                neg_q;
  logic                busy_q;
  logic [W-1:0]        top_q;

  logic [W-1:0] rdata;
  logic [AW-1:0] raddr;
  logic [PW-1:0] tm1, tm2;

  assign tm1 = ptr_q - PW'(1);
  assign tm2 = ptr_q - PW'(2);

  always_comb begin
    unique case (cmd_i.rd_sel)
      pse_pkg::RD_SEL_TOP:  raddr = tm1[AW-1:0];
      pse_pkg::RD_SEL_NEXT: raddr = tm2[AW-1:0];
      default:              raddr = tm1[AW-1:0];
    endcase
  end

  // signed quotient from magnitudes
  logic signed [65:0] qsig;
  logic [W-1:0] dres;
  logic dsat;
  assign qsig = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  always_comb begin
    dres = pse_pkg::sat32(qsig, dsat);
  end

  logic we;
  logic [AW-1:0] waddr;
  logic [W-1:0] wdata;
  logic do_push;

  assign do_push = (func_q == pse_pkg::FUNC_PUSH) && (ptr_q < PW'(pse_pkg::StackDepth - 1));
  assign we    = cmd_i.commit && (do_push || (stat_o.is_op && !stat_o.underflow && !fault_q));
  assign waddr = do_push ? ptr_q[AW-1:0] : tm2[AW-1:0];
  assign wdata = do_push ? push_q : ((func_q == pse_pkg::FUNC_DIV) ? dres : r_q);

  pse_ram #(.Width(W), .Depth(pse_pkg::StackDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(cmd_i.rd_en), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign stat_o.is_push   = (func_q == pse_pkg::FUNC_PUSH);
  assign stat_o.is_clear  = (func_q == pse_pkg::FUNC_CLEAR);
  assign stat_o.is_op     = (func_q >= pse_pkg::FUNC_ADD) && (func_q <= pse_pkg::FUNC_POW);
  assign stat_o.underflow = (ptr_q < PW'(2));
  assign stat_o.full      = !do_push;
  assign stat_o.fault     = fault_q;
  assign stat_o.iter_done = !busy_q;
  assign stat_o.nonempty  = (ptr_q != '0);

  // one Q16.16 multiply step with floor rounding (arith shift floors)
  logic signed [63:0] prod;
  logic [W-1:0] mres;
  logic msat;
  assign prod = r_q * a_q;
  always_comb begin
    mres = pse_pkg::sat32(66'(prod >>> 16), msat);
  end

  // add/sub
  logic [W-1:0] asres;
  logic assat;
  always_comb begin
    if (func_q == pse_pkg::FUNC_ADD)
      asres = pse_pkg::sat32(66'(a_q) + 66'(b_q), assat);
    else
      asres = pse_pkg::sat32(66'(a_q) - 66'(b_q), assat);
  end

  logic [64:0] rem_sh;
  logic [W-1:0] bmag;
  assign bmag   = b_q[W-1] ? W'(-b_q) : b_q;
  assign rem_sh = {rem_q, dvd_q[63]};

  logic signed [W-1:0] ib;
  assign ib = b_q >>> 16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cmd_i.exec)
        busy_q <= (func_q == pse_pkg::FUNC_MUL) ||
                  (func_q == pse_pkg::FUNC_DIV && b_q != '0) ||
                  (func_q == pse_pkg::FUNC_POW && !b_q[W-1] && ib <= W'(pse_pkg::MaxExponent)
                   && ib != '0);
      else if (cmd_i.iter && busy_q && cnt_q == 8'd1)
        busy_q <= 1'b0;
      if (cmd_i.commit) begin
        if (func_q == pse_pkg::FUNC_CLEAR) ptr_q <= '0;
        else if (do_push) ptr_q <= ptr_q + PW'(1);
        else if (stat_o.is_op && !stat_o.underflow && !fault_q) ptr_q <= ptr_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      func_q  <= func_i;
      push_q  <= operand_value_i;
      fault_q <= 1'b0;
      sat_q   <= 1'b0;
    end
    if (cmd_i.latch_b) b_q <= rdata;
    if (cmd_i.latch_a) a_q <= rdata;
    if (cmd_i.exec) begin
      cnt_q <= 8'd0;
      unique case (func_q)
        pse_pkg::FUNC_ADD, pse_pkg::FUNC_SUB: begin
          r_q <= asres; sat_q <= assat;
        end
        pse_pkg::FUNC_MUL: begin
          r_q <= b_q; cnt_q <= 8'd1;   // one pass of the shared multiplier: TOP * NEXT
        end
        pse_pkg::FUNC_DIV: begin
          if (b_q == '0) fault_q <= 1'b1;
          rem_q <= '0;
          quo_q <= '0;
          dvd_q <= {16'd0, (a_q[W-1] ? W'(-a_q) : a_q), 16'd0};
          neg_q <= a_q[W-1] ^ b_q[W-1];
          cnt_q <= 8'd64;
        end
        pse_pkg::FUNC_POW: begin
          if (b_q[W-1] || ib > W'(pse_pkg::MaxExponent)) fault_q <= 1'b1;
          r_q   <= 32'h00010000;
          cnt_q <= ib[7:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.iter && busy_q) begin
      cnt_q <= cnt_q - 8'd1;
      if (func_q == pse_pkg::FUNC_DIV) begin
        dvd_q <= dvd_q << 1;
        if (rem_sh >= {33'd0, bmag}) begin
          rem_q <= 64'(rem_sh - {33'd0, bmag});
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh[63:0];
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end else begin
        r_q <= mres;
        if (msat) sat_q <= 1'b1;
      end
    end
    if (cmd_i.grab_top) top_q <= rdata;
  end

  logic [2:0] st_d;
  logic wsat;
  always_comb begin
    wsat = sat_q || (func_q == pse_pkg::FUNC_DIV && dsat);
    priority if (func_q == pse_pkg::FUNC_PUSH) st_d = do_push ? pse_pkg::ST_OK : pse_pkg::ST_OVER;
    else if (!stat_o.is_op)                   st_d = pse_pkg::ST_OK;
    else if (stat_o.underflow)                st_d = pse_pkg::ST_UNDER;
    else if (fault_q && func_q == pse_pkg::FUNC_DIV) st_d = pse_pkg::ST_DIV_ZERO;
    else if (fault_q)                         st_d = pse_pkg::ST_BAD_EXP;
    else if (wsat)                            st_d = pse_pkg::ST_SAT;
    else                                      st_d = pse_pkg::ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) st_q <= st_d;
  end

  assign top_value_o   = stat_o.nonempty ? top_q : '0;
  assign stack_depth_o = ptr_q[pse_pkg::DepthW-1:0];
  assign status_o      = st_q;
endmodule

[design/pse_checker.sv]
module pse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [9:0] stack_depth_o,
  input logic [2:0] status_o
);
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= pse_pkg::ST_SAT) else $error("bad status");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(stack_depth_o))
    else $error("result dropped");
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == pse_pkg::ST_OVER
      |-> stack_depth_o == pse_pkg::DepthW'(pse_pkg::StackDepth - 1))
    else $error("overflow below capacity");
endmodule

bind postfix_stack_evaluator pse_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .stack_depth_o, .status_o
);
